// ===== sv/pss_pkg.sv =====
// pss_pkg: shared constants, item types, state encoding and helper functions
// for the packed sprite store with palette
// no dependencies
package pss_pkg;

    localparam int MAX_WIDTH   = 128;
    localparam int MAX_HEIGHT  = 128;
    localparam int PAL_DEPTH   = 256;
    localparam int STORE_BYTES = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int PAL_IDX_W   = $clog2(PAL_DEPTH);
    localparam int PAL_CNT_W   = PAL_IDX_W + 1;
    // y * stride + byte offset: 8x8 product plus an 8-bit offset
    localparam int LOC_W       = 17;

    // item kinds
    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_PALETTE = 2'd1;
    localparam logic [1:0] KIND_READ    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_DEPTH  = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic [7:0]  pen_index;
        logic [7:0]  palette_index;
        logic [15:0] palette_color;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  pixel_value;
        logic [31:0] argb_color;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW,
        ST_PIX,
        ST_SLOT,
        ST_MOD,
        ST_PAL
    } state_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } pix_req_t;

    typedef struct packed {
        logic                 wr;
        logic                 rd;
        logic [PAL_IDX_W-1:0] addr;
        logic [15:0]          wdata;
    } pal_req_t;

    typedef struct packed {
        logic                 start;
        logic [7:0]           dividend;
        logic [PAL_CNT_W-1:0] divisor;
    } rem_req_t;

    typedef struct packed {
        logic       busy;
        logic       done;
        logic [7:0] rem;
    } rem_rsp_t;

    // low bpp bits set
    function automatic logic [7:0] bpp_mask(input logic [1:0] mode);
        logic [7:0] m;
        unique case (mode)
            2'd0:    m = 8'h01;
            2'd1:    m = 8'h03;
            2'd2:    m = 8'h0F;
            default: m = 8'hFF;
        endcase
        return m;
    endfunction

    // rgb565 to argb8888, opaque alpha, low bits zero
    function automatic logic [31:0] expand565(input logic [15:0] c);
        return {8'hFF, c[15:11], 3'b000, c[10:5], 2'b00, c[4:0], 3'b000};
    endfunction

endpackage

// ===== sv/pss_pixel_mem.sv =====
// pss_pixel_mem: single-port byte memory holding the packed pixels
// depends on pss_pkg
module pss_pixel_mem (
    input  logic              clk,
    input  pss_pkg::pix_req_t req,
    output logic [7:0]        rdata
);
    import pss_pkg::*;

    logic [7:0] mem [STORE_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem[req.addr] <= req.wdata;
            end
            else
            begin
                rdata_reg <= mem[req.addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/pss_palette.sv =====
// pss_palette: rgb565 palette memory with per-entry valid bits and used count
// depends on pss_pkg
module pss_palette (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pss_pkg::pal_req_t             req,
    output logic [15:0]                   color,
    output logic [pss_pkg::PAL_CNT_W-1:0] used
);
    import pss_pkg::*;

    logic [15:0]          mem [PAL_DEPTH];
    logic [15:0]          rdata_reg;
    logic                 rvalid_reg;
    logic [PAL_DEPTH-1:0] valid_reg;
    logic [PAL_DEPTH-1:0] valid_next;
    logic [PAL_CNT_W-1:0] used_reg;
    logic [PAL_CNT_W-1:0] used_next;
    logic [PAL_CNT_W-1:0] idx_p1;

    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd)
        begin
            rdata_reg  <= mem[req.addr];
            rvalid_reg <= valid_reg[req.addr];
        end
    end

    always_comb
    begin
        idx_p1     = {1'b0, req.addr} + PAL_CNT_W'(1);
        valid_next = valid_reg;
        used_next  = used_reg;
        if (req.wr)
        begin
            valid_next[req.addr] = 1'b1;
            if (idx_p1 > used_reg)
            begin
                used_next = idx_p1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            used_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            used_reg  <= used_next;
        end
    end

    // never-written entries read as zero
    assign color = rvalid_reg ? rdata_reg : 16'h0000;
    assign used  = used_reg;

endmodule

// ===== sv/pss_rem_unit.sv =====
// pss_rem_unit: restoring remainder, one quotient bit per cycle
// depends on pss_pkg
module pss_rem_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  pss_pkg::rem_req_t req,
    output pss_pkg::rem_rsp_t rsp
);
    import pss_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [2:0]           cnt_reg, cnt_next;
    logic [PAL_CNT_W-1:0] rem_reg, rem_next;
    logic [7:0]           dvd_reg, dvd_next;
    logic [PAL_CNT_W-1:0] dvs_reg, dvs_next;
    logic [PAL_CNT_W-1:0] partial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        // remainder stays below divisor, so the shifted value fits
        partial   = {rem_reg[PAL_CNT_W-2:0], dvd_reg[7]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 3'd7;
            rem_next  = '0;
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = (partial >= dvs_reg) ? partial - dvs_reg : partial;
            dvd_next = {dvd_reg[6:0], 1'b0};
            cnt_next = cnt_reg - 3'd1;
            if (cnt_reg == 3'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg[7:0];

endmodule

// ===== sv/packed_sprite_store_palette_core.sv =====
// packed_sprite_store_palette_core: top level of the packed sprite store,
// with controller, pixel byte memory, palette and remainder unit
// depends on pss_pkg, pss_pixel_mem, pss_palette, pss_rem_unit
//
// channel   direction  handshake             payload
// in        input      in_valid / in_ready    in_data   (pss_pkg::in_item_t)
// out       output     out_valid / out_ready  out_data  (pss_pkg::out_item_t)
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a write-pixel item reads its byte, then merges and writes it back,
// a palette item is written as it is taken, a read-pixel item reads its
// pixel byte, then the palette entry, and a slot modulo that is not a
// plain index first goes through the bit-serial remainder unit
// after reset a clearing pass zeroes the pixel memory, one byte a cycle,
// over all STORE_BYTES bytes (16384 by default); no item is taken meanwhile
// a finished result waits in an output register, so new items are taken while
// out_ready is low; a second read result stalls until the first one leaves
// cfg is always ready
module packed_sprite_store_palette_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pss_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output pss_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);
    import pss_pkg::*;

    // configuration registers
    logic [1:0] depth_mode_reg;
    logic [7:0] sprite_width_reg;
    logic [7:0] sprite_height_reg;

    // controller state
    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [2:0]        shift_reg, shift_next;
    logic [7:0]        cidx_reg, cidx_next;
    logic [7:0]        value_reg, value_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;

    // sub-block ports
    pix_req_t             pix_req;
    logic [7:0]           pix_rdata;
    pal_req_t             pal_req;
    logic [15:0]          pal_color;
    logic [PAL_CNT_W-1:0] pal_used;
    rem_req_t             rem_req;
    rem_rsp_t             rem_rsp;

    // geometry and pixel location
    logic [7:0]       w_eff, h_eff;
    logic [3:0]       bpp;
    logic [7:0]       mask;
    logic [10:0]      line_bits;
    logic [7:0]       stride;
    logic [10:0]      x_bits;
    logic [15:0]      row_base;
    logic [LOC_W-1:0] loc_c;
    logic [2:0]       shift_c;
    logic             in_range_c;
    logic             accept;
    logic             clear_last;
    logic             out_free;

    // palette slot selection
    logic [PAL_CNT_W-1:0] slot_pow;
    logic [PAL_CNT_W-1:0] slot_lim;
    logic [PAL_CNT_W-1:0] slots_c;
    logic                 slot_direct;

    // byte merge and extract
    logic [7:0] mask_sh;
    logic [7:0] merged;
    logic [7:0] extracted;

    pss_pixel_mem u_pixel_mem (
        .clk   (clk),
        .req   (pix_req),
        .rdata (pix_rdata)
    );

    pss_palette u_palette (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (pal_req),
        .color (pal_color),
        .used  (pal_used)
    );

    pss_rem_unit u_rem_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .rsp   (rem_rsp)
    );

    // configuration writes, index beyond the list is dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_mode_reg    <= 2'd3;
            sprite_width_reg  <= 8'd128;
            sprite_height_reg <= 8'd128;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DEPTH:  depth_mode_reg    <= cfg_data[1:0];
                CFG_WIDTH:  sprite_width_reg  <= cfg_data;
                CFG_HEIGHT: sprite_height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // locate the addressed pixel: byte address, bit shift and range check
    always_comb
    begin
        w_eff = (32'(sprite_width_reg) > 32'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : sprite_width_reg;
        h_eff = (32'(sprite_height_reg) > 32'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT)
                                                           : sprite_height_reg;
        bpp       = 4'(4'd1 << depth_mode_reg);
        mask      = bpp_mask(depth_mode_reg);
        line_bits = {3'b000, w_eff} << depth_mode_reg;
        // stride rounds the row up to whole bytes
        stride    = 8'((line_bits + 11'd7) >> 3);
        x_bits    = {3'b000, in_data.pixel_x} << depth_mode_reg;
        row_base  = {8'h00, in_data.pixel_y} * {8'h00, stride};
        loc_c     = LOC_W'(row_base) + LOC_W'(x_bits[10:3]);
        // leftmost pixel sits in the high bits of the byte
        shift_c   = 3'(4'd8 - bpp - {1'b0, x_bits[2:0]});
        in_range_c = (in_data.pixel_x < w_eff) && (in_data.pixel_y < h_eff)
                  && (32'(loc_c) < 32'(STORE_BYTES));
    end

    // slot count is min(2^bpp, used entries), at least one
    always_comb
    begin
        slot_pow    = PAL_CNT_W'(1) << bpp;
        slot_lim    = (pal_used < slot_pow) ? pal_used : slot_pow;
        slots_c     = (slot_lim == '0) ? PAL_CNT_W'(1) : slot_lim;
        slot_direct = ({1'b0, value_reg} < slots_c);
    end

    always_comb
    begin
        mask_sh   = 8'(mask << shift_reg);
        merged    = (pix_rdata & ~mask_sh) | 8'((cidx_reg & mask) << shift_reg);
        extracted = 8'(pix_rdata >> shift_reg) & mask;
    end

    assign accept     = in_valid && in_ready;
    assign clear_last = (clr_reg == ADDR_W'(STORE_BYTES - 1));
    assign out_free   = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.kind == KIND_WRITE && in_range_c)
                    begin
                        state_next = ST_RMW;
                    end
                    else if (in_data.kind == KIND_READ)
                    begin
                        state_next = in_range_c ? ST_PIX : ST_SLOT;
                    end
                end
            end
            ST_RMW:  state_next = ST_IDLE;
            ST_PIX:  state_next = ST_SLOT;
            ST_SLOT: state_next = slot_direct ? ST_PAL : ST_MOD;
            ST_MOD:
            begin
                if (rem_rsp.done)
                begin
                    state_next = ST_PAL;
                end
            end
            ST_PAL:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs toward the memories and the remainder unit
    always_comb
    begin
        in_ready         = 1'b0;
        pix_req          = '0;
        pal_req          = '0;
        rem_req          = '0;
        rem_req.dividend = value_reg;
        rem_req.divisor  = slots_c;
        unique case (state_reg)
            ST_CLEAR:
            begin
                pix_req.en    = 1'b1;
                pix_req.we    = 1'b1;
                pix_req.addr  = clr_reg;
                pix_req.wdata = 8'h00;
            end
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                pix_req.addr = ADDR_W'(loc_c);
                if (in_valid)
                begin
                    if ((in_data.kind == KIND_WRITE || in_data.kind == KIND_READ)
                        && in_range_c)
                    begin
                        pix_req.en = 1'b1;
                    end
                    if (in_data.kind == KIND_PALETTE)
                    begin
                        pal_req.wr    = 1'b1;
                        pal_req.addr  = in_data.palette_index;
                        pal_req.wdata = in_data.palette_color;
                    end
                end
            end
            ST_RMW:
            begin
                pix_req.en    = 1'b1;
                pix_req.we    = 1'b1;
                pix_req.addr  = addr_reg;
                pix_req.wdata = merged;
            end
            ST_SLOT:
            begin
                if (slot_direct)
                begin
                    pal_req.rd   = 1'b1;
                    pal_req.addr = value_reg;
                end
                else
                begin
                    rem_req.start = 1'b1;
                end
            end
            ST_MOD:
            begin
                if (rem_rsp.done)
                begin
                    pal_req.rd   = 1'b1;
                    pal_req.addr = rem_rsp.rem;
                end
            end
            ST_PIX, ST_PAL: ;
            default: ;
        endcase
    end

    // item data registers and the output register
    always_comb
    begin
        clr_next       = clr_reg;
        addr_next      = addr_reg;
        shift_next     = shift_reg;
        cidx_next      = cidx_reg;
        value_next     = value_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == ST_CLEAR)
        begin
            clr_next = clr_reg + ADDR_W'(1);
        end
        if (accept)
        begin
            addr_next  = ADDR_W'(loc_c);
            shift_next = shift_c;
            cidx_next  = in_data.pen_index;
            // out-of-range read gives index zero
            value_next = 8'h00;
        end
        if (state_reg == ST_PIX)
        begin
            value_next = extracted;
        end
        if (state_reg == ST_PAL && out_free)
        begin
            out_next.pixel_value = value_reg;
            out_next.argb_color  = expand565(pal_color);
            out_valid_next       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        shift_reg <= shift_next;
        cidx_reg  <= cidx_next;
        value_reg <= value_next;
        out_reg   <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTH
    // the remainder unit is idle whenever a new item can be taken
    a_idle_rem: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !rem_rsp.busy)
        else $error("remainder unit busy while taking items");

    // pixel bytes are written only by the clearing pass or a write-back
    a_pix_write: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_req.en && pix_req.we) |-> (state_reg == ST_CLEAR || state_reg == ST_RMW))
        else $error("pixel memory written outside clear or write-back");

    // a write-back returns to idle in the next cycle
    a_rmw_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RMW) |=> (state_reg == ST_IDLE))
        else $error("write-back did not finish in one cycle");

    // a read result with a free output register shows up next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAL && out_free) |=> out_valid)
        else $error("read result lost");
`endif

endmodule

// ===== tb/pss_checker.sv =====
`timescale 1ns / 100ps
// pss_checker: watches the item, result and register channels of the sprite store,
// keeps its own copy of pixel bytes, palette and geometry, and compares every result
// depends on pss_pkg
module pss_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  pss_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  pss_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    output int                 mismatches,
    output int                 outstanding
);
    import pss_pkg::*;

    logic [7:0]  pix_bytes [STORE_BYTES];
    logic [15:0] pal_colors [PAL_DEPTH];
    logic [8:0]  pal_used;
    logic [1:0]  depth_q;
    logic [7:0]  width_q;
    logic [7:0]  height_q;

    out_item_t   read_q [$];

    initial mismatches = 0;

    // byte address and bit shift of a pixel, false when out of range
    function automatic bit locate_pixel(input logic [7:0] x, input logic [7:0] y,
                                        output int unsigned addr, output int unsigned shift);
        int unsigned bpp;
        int unsigned w;
        int unsigned h;
        int unsigned stride;
        int unsigned bitpos;
        addr   = 0;
        shift  = 0;
        bpp    = 1 << depth_q;
        w      = (width_q > MAX_WIDTH) ? MAX_WIDTH : width_q;
        h      = (height_q > MAX_HEIGHT) ? MAX_HEIGHT : height_q;
        if (x >= w || y >= h)
            return 1'b0;
        stride = (w * bpp + 7) >> 3;
        bitpos = x * bpp;
        addr   = y * stride + (bitpos >> 3);
        shift  = 8 - bpp - (bitpos & 7);
        return addr < STORE_BYTES;
    endfunction

    function automatic logic [31:0] argb_of(input logic [15:0] c);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = 8'((c >> 11) & 16'h1F) << 3;
        g = 8'((c >> 5) & 16'h3F) << 2;
        b = 8'(c & 16'h1F) << 3;
        return {8'hFF, r, g, b};
    endfunction

    task automatic flag(input string field, input logic [31:0] want, input logic [31:0] got);
        mismatches++;
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
    endtask

    task automatic take_item(input in_item_t it);
        int unsigned addr;
        int unsigned shift;
        int unsigned bpp;
        int unsigned slots;
        logic [7:0]  mask;
        logic [7:0]  byte_v;
        logic [7:0]  value;
        out_item_t   res;
        bpp  = 1 << depth_q;
        mask = 8'((1 << bpp) - 1);
        case (it.kind)
            KIND_WRITE:
            begin
                if (locate_pixel(it.pixel_x, it.pixel_y, addr, shift))
                begin
                    byte_v = pix_bytes[addr];
                    byte_v = (byte_v & ~(mask << shift)) | ((it.pen_index & mask) << shift);
                    pix_bytes[addr] = byte_v;
                end
            end
            KIND_PALETTE:
            begin
                pal_colors[it.palette_index] = it.palette_color;
                if (int'(it.palette_index) + 1 > int'(pal_used))
                    pal_used = 9'(int'(it.palette_index) + 1);
            end
            KIND_READ:
            begin
                value = '0;
                if (locate_pixel(it.pixel_x, it.pixel_y, addr, shift))
                    value = (pix_bytes[addr] >> shift) & mask;
                slots = 1 << bpp;
                if (slots > pal_used)
                    slots = pal_used;
                if (slots < 1)
                    slots = 1;
                res.pixel_value = value;
                res.argb_color  = argb_of(pal_colors[value % slots]);
                read_q.push_back(res);
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        out_item_t want;
        if (!rst_n)
        begin
            foreach (pix_bytes[i])
                pix_bytes[i] = '0;
            foreach (pal_colors[i])
                pal_colors[i] = '0;
            pal_used = '0;
            depth_q  = 2'd3;
            width_q  = 8'd128;
            height_q = 8'd128;
            read_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DEPTH:  depth_q  = cfg_data[1:0];
                    CFG_WIDTH:  width_q  = cfg_data;
                    CFG_HEIGHT: height_q = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            // results leave before the item of this edge can add one
            if (out_valid && out_ready)
            begin
                if (read_q.size() == 0)
                begin
                    mismatches++;
                    $error("result with nothing pending: pixel_value 0x%0h argb_color 0x%0h",
                           out_data.pixel_value, out_data.argb_color);
                end
                else
                begin
                    want = read_q.pop_front();
                    if (out_data.pixel_value !== want.pixel_value)
                        flag("pixel_value", want.pixel_value, out_data.pixel_value);
                    if (out_data.argb_color !== want.argb_color)
                        flag("argb_color", want.argb_color, out_data.argb_color);
                end
            end
            if (in_valid && in_ready)
                take_item(in_data);
            outstanding <= read_q.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// tb: stimulus and verdict for packed_sprite_store_palette_core
// depends on pss_pkg, the core and pss_checker
module tb;
    import pss_pkg::*;

    // kind and register index that the block has to ignore
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [1:0] CFG_SPARE   = 2'd3;

    localparam int NUM_PHASES      = 9;
    localparam int ITEMS_PER_PHASE = 128;
    // margin for the longest read and for a write still in flight
    localparam int SETTLE_CYCLES   = 24;
    // the clearing pass after reset alone is quiet over all STORE_BYTES bytes
    localparam int WATCHDOG_LIMIT  = 60000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data  = '0;

    int mismatches;
    int outstanding;
    int stall_pct = 0;
    int idle_pct  = 0;
    int quiet     = 0;

    // geometry in effect, used only to aim coordinates at the sprite
    int geom_w  = MAX_WIDTH;
    int geom_h  = MAX_HEIGHT;
    // highest palette slot that random items touch, grows over the run
    int pal_cap = 3;

    // per-phase register settings, the last phase draws its own
    logic [1:0] phase_depth  [NUM_PHASES] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd3, 2'd2, 2'd1, 2'd0, 2'd0};
    logic [7:0] phase_width  [NUM_PHASES] = '{8'd128, 8'd37, 8'd5, 8'd255, 8'd1, 8'd128, 8'd0,
                                             8'd128, 8'd0};
    logic [7:0] phase_height [NUM_PHASES] = '{8'd128, 8'd9, 8'd128, 8'd255, 8'd1, 8'd3, 8'd128,
                                             8'd0, 8'd0};
    int         phase_cap    [NUM_PHASES] = '{5, 7, 12, 20, 60, 255, 255, 255, 255};

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    packed_sprite_store_palette_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pss_checker check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // receiver stalls at the rate of the current phase
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    // watchdog: any handshake on any channel counts as progress
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    function automatic in_item_t make_item(input logic [1:0] kind, input logic [7:0] x,
                                           input logic [7:0] y, input logic [7:0] cidx,
                                           input logic [7:0] pidx, input logic [15:0] pcol);
        in_item_t it;
        it.kind          = kind;
        it.pixel_x       = x;
        it.pixel_y       = y;
        it.pen_index     = cidx;
        it.palette_index = pidx;
        it.palette_color = pcol;
        return it;
    endfunction

    // mostly in-range accesses, each coordinate half the time in a small window so reads
    // find written pixels, the rest anywhere in the 8-bit coordinate space
    function automatic in_item_t random_item();
        in_item_t    it;
        int unsigned pick;
        int unsigned span;
        it.pixel_x       = 8'($urandom_range(255));
        it.pixel_y       = 8'($urandom_range(255));
        it.pen_index     = 8'($urandom_range(255));
        it.palette_color = 16'($urandom_range(65535));
        it.palette_index = 8'($urandom_range(pal_cap, 0));
        pick = $urandom_range(99);
        if (pick < 40)
            it.kind = KIND_WRITE;
        else if (pick < 55)
            it.kind = KIND_PALETTE;
        else if (pick < 95)
            it.kind = KIND_READ;
        else
            it.kind = KIND_UNUSED;
        if ($urandom_range(99) < 85 && geom_w > 0 && geom_h > 0)
        begin
            span = ($urandom_range(1) == 1 || geom_w < 8) ? geom_w : 8;
            it.pixel_x = 8'($urandom_range(span - 1, 0));
            span = ($urandom_range(1) == 1 || geom_h < 8) ? geom_h : 8;
            it.pixel_y = 8'($urandom_range(span - 1, 0));
        end
        return it;
    endfunction

    // valid is only lowered while idling, so back-to-back items keep it high
    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // all three registers plus a write to the unused index, block idle
    task automatic configure(input logic [1:0] depth, input logic [7:0] w, input logic [7:0] h);
        write_reg(CFG_DEPTH, {6'd0, depth});
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_SPARE, 8'($urandom_range(255)));
        cfg_valid <= 1'b0;
        geom_w = (w > MAX_WIDTH) ? MAX_WIDTH : w;
        geom_h = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
    endtask

    // sender holds off until every read result is back and writes have settled
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [1:0] depth;
        logic [7:0] w;
        logic [7:0] h;
        int         mode;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed part under the reset geometry: 8 bpp, 128 x 128
        // read before any palette entry: slot count clamps to one
        send_item(make_item(KIND_READ, 8'd0, 8'd0, 8'hFF, 8'hFF, 16'hFFFF));
        send_item(make_item(KIND_PALETTE, 8'd0, 8'd0, 8'd0, 8'd0, 16'hFFFF));
        send_item(make_item(KIND_PALETTE, 8'hFF, 8'hFF, 8'hFF, 8'd1, 16'hF800));
        // corners of the sprite, one with the highest index
        send_item(make_item(KIND_WRITE, 8'd0, 8'd0, 8'hFF, 8'd0, 16'h0000));
        send_item(make_item(KIND_WRITE, 8'd127, 8'd127, 8'hA5, 8'd0, 16'h0000));
        send_item(make_item(KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000));
        send_item(make_item(KIND_READ, 8'd127, 8'd127, 8'd0, 8'd0, 16'h0000));
        // writes outside the sprite are dropped
        send_item(make_item(KIND_WRITE, 8'd128, 8'd3, 8'h5A, 8'd0, 16'h0000));
        send_item(make_item(KIND_WRITE, 8'd3, 8'd128, 8'h5A, 8'd0, 16'h0000));
        send_item(make_item(KIND_WRITE, 8'hFF, 8'hFF, 8'h5A, 8'd0, 16'h0000));
        // out-of-range reads give index zero
        send_item(make_item(KIND_READ, 8'd128, 8'd3, 8'd0, 8'd0, 16'h0000));
        send_item(make_item(KIND_READ, 8'd3, 8'd128, 8'd0, 8'd0, 16'h0000));
        send_item(make_item(KIND_READ, 8'hFF, 8'hFF, 8'd0, 8'd0, 16'h0000));
        // unused kind changes nothing
        send_item(make_item(KIND_UNUSED, 8'd0, 8'd0, 8'h11, 8'd0, 16'h1234));
        send_item(make_item(KIND_PALETTE, 8'd0, 8'd0, 8'd0, 8'd2, 16'h07E0));
        send_item(make_item(KIND_PALETTE, 8'd0, 8'd0, 8'd0, 8'd3, 16'h001F));
        send_item(make_item(KIND_READ, 8'd127, 8'd127, 8'd0, 8'd0, 16'h0000));
        send_item(make_item(KIND_READ, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000));
        send_item(make_item(KIND_WRITE, 8'd5, 8'd0, 8'h00, 8'd0, 16'h0000));
        send_item(make_item(KIND_READ, 8'd5, 8'd0, 8'd0, 8'd0, 16'h0000));
        send_item(make_item(KIND_READ, 8'd3, 8'd128, 8'd0, 8'd0, 16'h0000));

        // random phases: new geometry each time over the same pixel bytes,
        // cycling through no idling, sender idle, receiver stalling, both
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            if (p == NUM_PHASES - 1)
            begin
                depth = 2'($urandom_range(3));
                w     = 8'($urandom_range(255));
                h     = 8'($urandom_range(255));
            end
            else
            begin
                depth = phase_depth[p];
                w     = phase_width[p];
                h     = phase_height[p];
            end
            configure(depth, w, h);
            pal_cap = phase_cap[p];
            mode    = p % 4;
            idle_pct   = (mode == 1) ? 67 : (mode == 3) ? 12 : 0;
            stall_pct <= (mode == 2) ? 67 : (mode == 3) ? 12 : 0;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_item(random_item());
        end

        drain();
        if (mismatches == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
